// ===== design/lmsd_pkg.sv =====
// shared types and constants of the led matrix scan driver
package lmsd_pkg;

  localparam int QDEPTH = 4;
  localparam int QW = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    TK_HOLD,
    TK_DATA,
    TK_CLK_LOW,
    TK_LATCH,
    TK_ADDR,
    TK_UNBLANK
  } tick_kind_t;

  typedef struct packed {
    tick_kind_t kind;
    logic [3:0] row;
    logic [5:0] data;
  } tick_t;

  typedef struct packed {
    logic [QW-1:0] level;
  } q_status_t;

endpackage

// ===== design/led_matrix_scan_driver.sv =====
// top level of the led matrix scan driver
// Scan driver for a two-half RGB LED panel. A word with tuser 0 writes one
// pixel into the frame store and gives no output; a word with tuser 1 is one
// scan tick and gives one pin snapshot. One word is taken per clock while
// s_axis_tready is high; a tick's store read is registered, queued and then
// registered at the output. The store has one read port per panel half, so
// both halves are read in the same cycle. After reset each half is cleared
// one entry per cycle, PANEL_HEIGHT/2 * PANEL_WIDTH entries (1024 by default),
// and no word is taken meanwhile; color depth writes are taken at any time.
module led_matrix_scan_driver
  import lmsd_pkg::*;
#(
  parameter int PANEL_HEIGHT = 32,
  parameter int PANEL_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_row, pixel_col, red_level, green_level, blue_level
  input  logic [39:0] s_axis_tdata,
  // opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red_upper, green_upper, blue_upper, red_lower, green_lower, blue_lower,
  // shift_clock, latch_strobe, blank_level, row_select
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  q_status_t q_status;
  logic      push_valid;
  tick_t     push_tick;

  assign cfg_ready = 1'b1;

  lmsd_front #(.PANEL_HEIGHT(PANEL_HEIGHT), .PANEL_WIDTH(PANEL_WIDTH)) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .q_status      (q_status),
    .push_valid    (push_valid),
    .push_tick     (push_tick)
  );

  lmsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .push_valid    (push_valid),
    .push_tick     (push_tick),
    .q_status      (q_status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== design/lmsd_ram.sv =====
// generic single write port ram with registered read
module lmsd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/lmsd_front.sv =====
// front end: accepts words, writes the frame store, steps the scan counters
module lmsd_front
  import lmsd_pkg::*;
#(
  parameter int PANEL_HEIGHT = 32,
  parameter int PANEL_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_data,
  input  q_status_t   q_status,
  output logic        push_valid,
  output tick_t       push_tick
);

  localparam int HALF = PANEL_HEIGHT / 2;
  localparam int DEPTH = HALF * PANEL_WIDTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int CW = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;

  logic [7:0]    plane_limit;
  logic [7:0]    plane_count, plane_count_next;
  logic [PW-1:0] pair_count, pair_count_next;
  logic [CW-1:0] column_count, column_count_next;
  logic [1:0]    phase_count, phase_count_next;
  logic          in_tail, in_tail_next;
  tick_kind_t    kind_next;

  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  logic          s1_valid;
  tick_kind_t    s1_kind;
  logic [3:0]    s1_row;
  logic [7:0]    s1_plane;

  logic [4:0]    pix_row;
  logic [5:0]    pix_col;
  logic [23:0]   pix_rgb;
  logic          take, tick_go, wr_go;
  logic          up_we, lo_we;
  logic [AW-1:0] wr_addr, ram_wa, rd_addr;
  logic [23:0]   ram_wd, up_rd, lo_rd;
  logic [PW+3:0] pair_ext;
  logic [4:0]    room;
  logic [8:0]    plane_inc;

  assign pix_row = s_axis_tdata[4:0];
  assign pix_col = s_axis_tdata[10:5];
  assign pix_rgb = {s_axis_tdata[34:27], s_axis_tdata[26:19], s_axis_tdata[18:11]};

  assign room = 5'(q_status.level) + 5'(s1_valid);
  assign s_axis_tready = !clr_busy && (room < 5'(QDEPTH));
  assign take = s_axis_tvalid && s_axis_tready;
  assign tick_go = take && s_axis_tuser;
  assign wr_go = take && !s_axis_tuser;

  // write address and half select
  always_comb begin
    up_we = 1'b0;
    lo_we = 1'b0;
    wr_addr = '0;
    if (32'(pix_col) < PANEL_WIDTH) begin
      if (32'(pix_row) < HALF) begin
        up_we = wr_go;
        wr_addr = AW'(32'(pix_row) * PANEL_WIDTH + 32'(pix_col));
      end else if (32'(pix_row) < 2 * HALF) begin
        lo_we = wr_go;
        wr_addr = AW'((32'(pix_row) - HALF) * PANEL_WIDTH + 32'(pix_col));
      end
    end
  end

  assign ram_wa = clr_busy ? clr_addr : wr_addr;
  assign ram_wd = clr_busy ? 24'd0 : pix_rgb;
  assign rd_addr = AW'(32'(pair_count) * PANEL_WIDTH + 32'(column_count));

  lmsd_ram #(.WIDTH(24), .DEPTH(DEPTH), .AW(AW)) u_upper (
    .clk     (clk),
    .we      (clr_busy || up_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (rd_addr),
    .rd_data (up_rd)
  );

  lmsd_ram #(.WIDTH(24), .DEPTH(DEPTH), .AW(AW)) u_lower (
    .clk     (clk),
    .we      (clr_busy || lo_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_addr (rd_addr),
    .rd_data (lo_rd)
  );

  assign plane_inc = {1'b0, plane_count} + 9'd1;
  assign pair_ext = {4'd0, pair_count};

  // scan sequencing
  always_comb begin
    plane_count_next = plane_count;
    pair_count_next = pair_count;
    column_count_next = column_count;
    phase_count_next = phase_count;
    in_tail_next = in_tail;
    kind_next = TK_HOLD;
    if (plane_limit != 8'd0) begin
      if (!in_tail) begin
        if (phase_count == 2'd0) begin
          kind_next = TK_DATA;
          phase_count_next = 2'd1;
        end else begin
          kind_next = TK_CLK_LOW;
          phase_count_next = 2'd0;
          if (column_count == CW'(PANEL_WIDTH - 1)) begin
            column_count_next = '0;
            in_tail_next = 1'b1;
          end else begin
            column_count_next = column_count + 1'b1;
          end
        end
      end else begin
        case (phase_count)
          2'd0: begin
            kind_next = TK_LATCH;
            phase_count_next = 2'd1;
          end
          2'd1: begin
            kind_next = TK_ADDR;
            phase_count_next = 2'd2;
          end
          default: begin
            kind_next = TK_UNBLANK;
            phase_count_next = 2'd0;
            in_tail_next = 1'b0;
            if (pair_count == PW'(HALF - 1)) begin
              pair_count_next = '0;
              if (plane_inc >= {1'b0, plane_limit}) begin
                plane_count_next = '0;
              end else begin
                plane_count_next = plane_inc[7:0];
              end
            end else begin
              pair_count_next = pair_count + 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_limit <= 8'd255;
      plane_count <= '0;
      pair_count <= '0;
      column_count <= '0;
      phase_count <= '0;
      in_tail <= 1'b0;
      clr_busy <= 1'b1;
      clr_addr <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        plane_limit <= cfg_data;
      end
      if (clr_busy) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      s1_valid <= tick_go;
      if (tick_go) begin
        plane_count <= plane_count_next;
        pair_count <= pair_count_next;
        column_count <= column_count_next;
        phase_count <= phase_count_next;
        in_tail <= in_tail_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      s1_kind <= kind_next;
      s1_row <= pair_ext[3:0];
      s1_plane <= plane_count;
    end
  end

  // compare stored levels against the plane threshold
  assign push_valid = s1_valid;
  always_comb begin
    push_tick.kind = s1_kind;
    push_tick.row = s1_row;
    push_tick.data = {lo_rd[23:16] > s1_plane, lo_rd[15:8] > s1_plane,
                      lo_rd[7:0] > s1_plane, up_rd[23:16] > s1_plane,
                      up_rd[15:8] > s1_plane, up_rd[7:0] > s1_plane};
  end

endmodule

// ===== design/lmsd_back.sv =====
// back end: tick queue, pin state and output register
module lmsd_back
  import lmsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  input  tick_t       push_tick,
  output q_status_t   q_status,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata
);

  localparam int PTRW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  tick_t           q_mem [QDEPTH];
  logic [PTRW-1:0] wr_ptr, rd_ptr;
  logic [QW-1:0]   count;
  logic            pop;
  tick_t           head;
  logic [12:0]     pin_state, pin_state_next;

  assign pop = (count != '0) && (!m_axis_tvalid || m_axis_tready);
  assign head = q_mem[rd_ptr];
  assign q_status.level = count;

  // pin order: ru gu bu rl gl bl clk lat blank row[3:0]
  always_comb begin
    pin_state_next = pin_state;
    case (head.kind)
      TK_DATA: begin
        pin_state_next[5:0] = head.data;
        pin_state_next[6] = 1'b1;
      end
      TK_CLK_LOW: pin_state_next[6] = 1'b0;
      TK_LATCH: begin
        pin_state_next[7] = 1'b1;
        pin_state_next[8] = 1'b1;
      end
      TK_ADDR: begin
        pin_state_next[7] = 1'b0;
        pin_state_next[12:9] = head.row;
      end
      TK_UNBLANK: pin_state_next[8] = 1'b0;
      default: pin_state_next = pin_state;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      pin_state <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (push_valid) begin
        wr_ptr <= (wr_ptr == PTRW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        pin_state <= pin_state_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      count <= count + QW'(push_valid) - QW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      q_mem[wr_ptr] <= push_tick;
    end
  end

  assign m_axis_tdata = {3'd0, pin_state};

endmodule

// ===== verif/led_matrix_scan_driver_tb.sv =====
// self-checking testbench for the led matrix scan driver
module led_matrix_scan_driver_tb;

  localparam int PANEL_H = 32;
  localparam int PANEL_W = 64;
  localparam int HALF_ROWS = PANEL_H / 2;
  localparam bit OP_WRITE = 1'b0;
  localparam bit OP_TICK = 1'b1;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [3:0] row_select;
    logic       blank_level;
    logic       latch_strobe;
    logic       shift_clock;
    logic       blue_lower;
    logic       green_lower;
    logic       red_lower;
    logic       blue_upper;
    logic       green_upper;
    logic       red_upper;
  } pin_snapshot_t;

  class scan_scoreboard;
    logic [7:0] red_mem [PANEL_H*PANEL_W];
    logic [7:0] green_mem [PANEL_H*PANEL_W];
    logic [7:0] blue_mem [PANEL_H*PANEL_W];
    logic [7:0] depth;
    logic [7:0] plane;
    logic [3:0] pair;
    logic [5:0] column;
    logic [1:0] phase;
    bit in_tail;
    pin_snapshot_t pins;
    pin_snapshot_t snapshots_due[$];
    int mismatches;
    int unexpected;
    int checked;
    int writes;
    int ticks;

    function new();
      foreach (red_mem[i]) begin
        red_mem[i] = '0;
        green_mem[i] = '0;
        blue_mem[i] = '0;
      end
      depth = 8'd255;
      plane = '0;
      pair = '0;
      column = '0;
      phase = '0;
      in_tail = 0;
      pins = '0;
      mismatches = 0;
      unexpected = 0;
      checked = 0;
      writes = 0;
      ticks = 0;
    endfunction

    function void set_depth(logic [7:0] value);
      depth = value;
    endfunction

    function int pending();
      return snapshots_due.size();
    endfunction

    function int failures();
      return mismatches + unexpected + snapshots_due.size();
    endfunction

    function void advance_scan();
      int upper;
      int lower;
      if (!in_tail) begin
        if (phase == 0) begin
          upper = pair * PANEL_W + column;
          lower = upper + HALF_ROWS * PANEL_W;
          pins.red_upper = red_mem[upper] > plane;
          pins.green_upper = green_mem[upper] > plane;
          pins.blue_upper = blue_mem[upper] > plane;
          pins.red_lower = red_mem[lower] > plane;
          pins.green_lower = green_mem[lower] > plane;
          pins.blue_lower = blue_mem[lower] > plane;
          pins.shift_clock = 1'b1;
          phase = 1;
        end else begin
          pins.shift_clock = 1'b0;
          phase = 0;
          if (column == PANEL_W - 1) in_tail = 1;
          column = column + 1'b1;
        end
      end else if (phase == 0) begin
        pins.latch_strobe = 1'b1;
        pins.blank_level = 1'b1;
        phase = 1;
      end else if (phase == 1) begin
        pins.latch_strobe = 1'b0;
        pins.row_select = pair;
        phase = 2;
      end else begin
        pins.blank_level = 1'b0;
        phase = 0;
        in_tail = 0;
        if (pair == HALF_ROWS - 1) begin
          if (int'(plane) + 1 >= int'(depth)) plane = '0;
          else plane = plane + 1'b1;
        end
        pair = pair + 1'b1;
      end
    endfunction

    function void note_word(bit op, logic [39:0] data);
      int addr;
      if (op == OP_WRITE) begin
        addr = int'(data[4:0]) * PANEL_W + int'(data[10:5]);
        red_mem[addr] = data[18:11];
        green_mem[addr] = data[26:19];
        blue_mem[addr] = data[34:27];
        writes++;
      end else begin
        if (depth != 0) advance_scan();
        snapshots_due.push_back(pins);
        ticks++;
      end
    endfunction

    function bit field_bad(string name, int unsigned want, int unsigned got, bit loud);
      if (want != got && loud)
        $display("  snapshot %0d %s: expected %0d, got %0d", checked, name, want, got);
      return want != got;
    endfunction

    function void check_snapshot(logic [15:0] data);
      pin_snapshot_t want;
      pin_snapshot_t got;
      bit loud;
      bit bad;
      got = data[12:0];
      if (snapshots_due.size() == 0) begin
        if (mismatches + unexpected < REPORT_LIMIT)
          $display("unexpected snapshot 0x%04h with nothing outstanding", data);
        unexpected++;
        return;
      end
      want = snapshots_due.pop_front();
      loud = mismatches + unexpected < REPORT_LIMIT;
      bad = 0;
      bad |= field_bad("red_upper", want.red_upper, got.red_upper, loud);
      bad |= field_bad("green_upper", want.green_upper, got.green_upper, loud);
      bad |= field_bad("blue_upper", want.blue_upper, got.blue_upper, loud);
      bad |= field_bad("red_lower", want.red_lower, got.red_lower, loud);
      bad |= field_bad("green_lower", want.green_lower, got.green_lower, loud);
      bad |= field_bad("blue_lower", want.blue_lower, got.blue_lower, loud);
      bad |= field_bad("shift_clock", want.shift_clock, got.shift_clock, loud);
      bad |= field_bad("latch_strobe", want.latch_strobe, got.latch_strobe, loud);
      bad |= field_bad("blank_level", want.blank_level, got.blank_level, loud);
      bad |= field_bad("row_select", want.row_select, got.row_select, loud);
      if (bad) mismatches++;
      checked++;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // pixel_row, pixel_col, red_level, green_level, blue_level
  logic [39:0] s_axis_tdata;
  // opcode
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // red_upper, green_upper, blue_upper, red_lower, green_lower, blue_lower,
  // shift_clock, latch_strobe, blank_level, row_select
  logic [15:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  scan_scoreboard sb;
  bit idling;
  bit hold_off_req;
  int cycle_count;
  logic [7:0] random_depth;

  led_matrix_scan_driver uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_snapshot(m_axis_tdata);
    end
  end

  // output side back-pressure
  initial begin
    m_axis_tready = 0;
    forever begin
      if (hold_off_req) begin
        m_axis_tready = 0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end else begin
        m_axis_tready = 1;
        @(negedge clk);
      end
    end
  end

  task automatic send_word(bit op, logic [39:0] data);
    @(negedge clk);
    if (idling && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tuser = op;
    s_axis_tdata = data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic write_pixel(int row, int col, int red, int green, int blue);
    send_word(OP_WRITE, {5'b0, 8'(blue), 8'(green), 8'(red), 6'(col), 5'(row)});
  endtask

  task automatic send_tick();
    send_word(OP_TICK, 40'({$urandom, $urandom}));
  endtask

  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_depth(logic [7:0] value);
    @(negedge clk);
    cfg_valid = 1;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_depth(value);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic int pick_level();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic run_mix(int count, int write_pct);
    repeat (count) begin
      if ($urandom_range(1, 100) <= write_pct)
        write_pixel($urandom_range(0, PANEL_H - 1), $urandom_range(0, PANEL_W - 1),
                    pick_level(), pick_level(), pick_level());
      else
        send_tick();
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tuser = 0;
    s_axis_tdata = '0;
    cfg_valid = 0;
    cfg_data = '0;
    idling = 0;
    hold_off_req = 0;
    cycle_count = 0;
    repeat (5) @(negedge clk);
    rst = 0;

    load_depth(8'd255);

    // corners, both halves and thresholds around zero
    write_pixel(0, 0, 255, 0, 1);
    write_pixel(16, 0, 1, 255, 128);
    write_pixel(31, 63, 255, 255, 255);
    write_pixel(15, 63, 127, 2, 0);
    write_pixel(0, 1, 0, 1, 255);
    write_pixel(16, 1, 255, 0, 0);
    repeat (6) send_tick();
    drain();
    // zero depth holds the pins
    load_depth(8'd0);
    repeat (3) send_tick();
    drain();
    load_depth(8'd255);
    repeat (2) send_tick();
    drain();

    idling = 1;
    random_depth = 8'($urandom_range(1, 255));
    load_depth(8'd1);
    run_mix(120, 25);
    drain();
    load_depth(8'd2);
    run_mix(120, 20);
    drain();
    load_depth(8'd255);
    hold_off_req = 1;
    run_mix(120, 15);
    drain();
    load_depth(8'd7);
    run_mix(60, 20);
    drain();
    run_mix(60, 20);
    drain();
    load_depth(random_depth);
    run_mix(120, 20);
    drain();

    // sweeps without idling across row pairs, then depth lowered mid-frame
    idling = 0;
    load_depth(8'd3);
    run_mix(170, 3);
    drain();
    load_depth(8'd1);
    run_mix(170, 3);
    drain();

    $display("covered %0d pixel writes and %0d scan ticks, %0d snapshots checked",
             sb.writes, sb.ticks, sb.checked);
    $display("color depths applied: 255, 0, 1, 2, 255, 7, %0d, 3 and 1 (lowered mid-frame)",
             random_depth);
    if (sb.failures() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing",
               sb.mismatches, sb.unexpected, sb.pending());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== led_matrix_scan_driver.f =====
design/lmsd_pkg.sv
design/lmsd_ram.sv
design/lmsd_front.sv
design/lmsd_back.sv
design/led_matrix_scan_driver.sv
verif/led_matrix_scan_driver_tb.sv
